[hw/rtl/owtr_pkg.sv]
`timescale 1ns / 1ps

package owtr_pkg;

    // Sequencer phases.
    typedef enum logic [1:0] {
        PH_CONVERT = 2'd0,
        PH_WAIT    = 2'd1,
        PH_READ    = 2'd2
    } t_phase;

    // One result item.
    typedef struct packed {
        logic               tx_valid;
        logic [7:0]         tx_byte;
        logic               slow_baud;
        logic               temp_valid;
        logic signed [11:0] temperature;
    } t_result;

    // Slot bytes and ROM commands.
    localparam logic [7:0] SLOT_RESET  = 8'hF0;
    localparam logic [7:0] SLOT_ZERO   = 8'h00;
    localparam logic [7:0] SLOT_ONE    = 8'hFF;
    localparam logic [7:0] CMD_SKIP    = 8'hCC;
    localparam logic [7:0] CMD_CONVERT = 8'h44;
    localparam logic [7:0] CMD_READ    = 8'hBE;

    // Slot layout: reset, eight skip bits, eight command bits, then data.
    localparam int CONVERT_SLOTS = 17;
    localparam int READ_FIRST    = 17;
    localparam int READ_BITS     = 16;

    // Sensor resolution; unused low bits read as zero.
    localparam int TEMP_W    = 12;
    localparam int TEMP_BITS = 12;
    localparam logic [TEMP_W-1:0] TEMP_MASK = {TEMP_W{1'b1}} << (TEMP_W - TEMP_BITS);

    // Configuration register map (word index in paddr[2]).
    localparam logic       REG_WAIT_TICKS   = 1'b0;
    localparam logic [7:0] WAIT_TICKS_RESET = 8'd2;

endpackage

[hw/rtl/owtr_if.sv]
`timescale 1ns / 1ps

// Input channel: one tick or one slot echo per transfer.
interface owtr_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] rx_byte;

    modport source (output valid, output action, output rx_byte, input ready);
    modport sink (input valid, input action, input rx_byte, output ready);
endinterface

// Output channel: one result per transfer.
interface owtr_out_if;
    logic               valid;
    logic               ready;
    logic               tx_valid;
    logic [7:0]         tx_byte;
    logic               slow_baud;
    logic               temp_valid;
    logic signed [11:0] temperature;

    modport source (output valid, output tx_valid, output tx_byte, output slow_baud,
                    output temp_valid, output temperature, input ready);
    modport sink (input valid, input tx_valid, input tx_byte, input slow_baud,
                  input temp_valid, input temperature, output ready);
endinterface

[hw/rtl/owtr_apb.sv]
`timescale 1ns / 1ps

module owtr_apb
    import owtr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [7:0]  o_wait_ticks
);

    logic [7:0] r_wait_ticks;
    logic       w_sel_wait;

    assign w_sel_wait = (paddr[2] == REG_WAIT_TICKS) && (paddr[1:0] == 2'd0);

    // Register write in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait_ticks <= WAIT_TICKS_RESET;
        end else if (psel && penable && pwrite && w_sel_wait) begin
            r_wait_ticks <= pwdata[7:0];
        end
    end

    // Read back.
    always_comb begin
        prdata = 32'd0;
        if (w_sel_wait) begin
            prdata = {24'd0, r_wait_ticks};
        end
    end

    assign pready       = 1'b1;
    assign o_wait_ticks = r_wait_ticks;

endmodule

[hw/rtl/owtr_seq.sv]
`timescale 1ns / 1ps

module owtr_seq
    import owtr_pkg::*;
#(
    parameter int READ_BYTES = 9
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic       i_action,
    input  logic [7:0] i_rx_byte,
    input  logic [7:0] i_wait_ticks,
    output t_result    o_result
);

    localparam int READ_SLOTS = READ_FIRST + 8 * READ_BYTES + 1;
    localparam int SLOT_W     = $clog2(READ_SLOTS + 1);
    localparam logic [SLOT_W-1:0] CONVERT_END = SLOT_W'(CONVERT_SLOTS);
    localparam logic [SLOT_W-1:0] READ_END    = SLOT_W'(READ_SLOTS);
    localparam logic [SLOT_W-1:0] LAST_READ   = SLOT_W'(READ_SLOTS - 1);
    localparam logic [SLOT_W-1:0] DATA_FIRST  = SLOT_W'(READ_FIRST);
    localparam logic [SLOT_W-1:0] DATA_END    = SLOT_W'(READ_FIRST + READ_BITS);

    t_phase            r_phase, n_phase, m_phase, w_phase;
    logic [SLOT_W-1:0] r_slot_index, n_slot_index, m_slot_index;
    logic              r_slot_pending, n_slot_pending, m_slot_pending;
    logic [7:0]        r_tick_count, n_tick_count;
    logic [15:0]       r_read_shift, n_read_shift;

    logic [SLOT_W-1:0]   w_slot_inc;
    logic [SLOT_W-1:0]   w_data_off;
    logic [2:0]          w_bit_sel;
    logic [7:0]          w_cmd;
    logic                w_temp_valid;
    logic signed [TEMP_W-1:0] w_temperature;
    t_result             w_result;

    assign w_slot_inc = r_slot_index + 1'b1;
    assign w_data_off = r_slot_index - DATA_FIRST;

    // An unused phase code behaves as the convert cycle.
    always_comb begin
        case (r_phase)
            PH_CONVERT, PH_WAIT, PH_READ: w_phase = r_phase;
            default:                      w_phase = PH_CONVERT;
        endcase
    end

    // Next state: take an echo or count a tick.
    always_comb begin
        m_phase        = w_phase;
        m_slot_index   = r_slot_index;
        m_slot_pending = r_slot_pending;
        n_tick_count   = r_tick_count;
        n_read_shift   = r_read_shift;
        w_temp_valid   = 1'b0;
        w_temperature  = '0;
        if (i_action && r_slot_pending && w_phase != PH_WAIT) begin
            m_slot_pending = 1'b0;
            if (w_phase == PH_READ && r_slot_index >= DATA_FIRST
                    && r_slot_index < DATA_END && i_rx_byte == SLOT_ONE) begin
                n_read_shift[w_data_off[3:0]] = 1'b1;
            end
            m_slot_index = w_slot_inc;
            if (w_phase == PH_READ) begin
                if (w_slot_inc >= READ_END) begin
                    // Read cycle done: present the low 12 bits of bytes 0 and 1.
                    w_temp_valid  = 1'b1;
                    w_temperature = n_read_shift[TEMP_W-1:0] & TEMP_MASK;
                    m_phase       = PH_CONVERT;
                    m_slot_index  = '0;
                    n_read_shift  = '0;
                end
            end else if (w_slot_inc >= CONVERT_END) begin
                m_phase      = PH_WAIT;
                n_tick_count = '0;
                m_slot_index = '0;
                if (i_wait_ticks == 8'd0) begin
                    m_phase        = PH_READ;
                    m_slot_pending = 1'b0;
                    n_read_shift   = '0;
                end
            end
        end else if (!i_action && w_phase == PH_WAIT) begin
            if (r_tick_count != 8'hFF) begin
                n_tick_count = r_tick_count + 8'd1;
            end
            if (n_tick_count >= i_wait_ticks) begin
                m_phase        = PH_READ;
                m_slot_index   = '0;
                m_slot_pending = 1'b0;
                n_read_shift   = '0;
            end
        end
    end

    // Slot issue: the byte for the current slot index.
    assign w_bit_sel = 3'(m_slot_index[2:0] - 3'd1);
    assign w_cmd     = (m_phase == PH_READ) ? CMD_READ : CMD_CONVERT;

    always_comb begin
        n_phase              = m_phase;
        n_slot_index         = m_slot_index;
        n_slot_pending       = m_slot_pending;
        w_result.tx_valid    = 1'b0;
        w_result.tx_byte     = 8'd0;
        w_result.slow_baud   = 1'b0;
        w_result.temp_valid  = w_temp_valid;
        w_result.temperature = w_temperature;
        if (m_phase != PH_WAIT && !m_slot_pending) begin
            n_slot_pending    = 1'b1;
            w_result.tx_valid = 1'b1;
            if (m_slot_index == '0) begin
                w_result.tx_byte   = SLOT_RESET;
                w_result.slow_baud = 1'b1;
            end else if (m_slot_index <= SLOT_W'(8)) begin
                w_result.tx_byte = CMD_SKIP[w_bit_sel] ? SLOT_ONE : SLOT_ZERO;
            end else if (m_slot_index <= SLOT_W'(16)) begin
                w_result.tx_byte = w_cmd[w_bit_sel] ? SLOT_ONE : SLOT_ZERO;
            end else if (m_phase == PH_READ && m_slot_index < LAST_READ) begin
                w_result.tx_byte = SLOT_ONE;
            end else begin
                w_result.tx_byte   = SLOT_RESET;
                w_result.slow_baud = 1'b1;
            end
        end
    end

    // State registers advance on each accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_CONVERT;
            r_slot_index   <= '0;
            r_slot_pending <= 1'b0;
            r_tick_count   <= '0;
            r_read_shift   <= '0;
        end else if (i_accept) begin
            r_phase        <= n_phase;
            r_slot_index   <= n_slot_index;
            r_slot_pending <= n_slot_pending;
            r_tick_count   <= n_tick_count;
            r_read_shift   <= n_read_shift;
        end
    end

    assign o_result = w_result;

endmodule

[hw/rtl/owtr_outreg.sv]
`timescale 1ns / 1ps

module owtr_outreg
    import owtr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_result    i_result,
    output logic       o_ready,
    owtr_out_if.source o_out
);

    logic    r_valid;
    t_result r_result;

    // A new result may enter when the register is empty or being drained.
    assign o_ready = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.tx_valid    = r_result.tx_valid;
    assign o_out.tx_byte     = r_result.tx_byte;
    assign o_out.slow_baud   = r_result.slow_baud;
    assign o_out.temp_valid  = r_result.temp_valid;
    assign o_out.temperature = r_result.temperature;

endmodule

[hw/rtl/onewire_uart_temp_reader.sv]
`timescale 1ns / 1ps
// Each result is registered and is on the output channel in the cycle after its input transfer.
// Throughput: one item per cycle; the sequencer next-state logic feeds one result register.
// The input stalls only while that result register is full and not being taken.
// Reset: synchronous, active low; the convert cycle restarts and wait_ticks returns to 2.

module onewire_uart_temp_reader
    import owtr_pkg::*;
#(
    parameter int READ_BYTES = 9
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    owtr_in_if.sink     i_in,
    owtr_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic       w_ready;
    logic       w_accept;
    logic [7:0] w_wait_ticks;
    t_result    w_result;

    assign i_in.ready = w_ready;
    assign w_accept   = i_in.valid && w_ready;

    // Configuration registers.
    owtr_apb u_apb (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_wait_ticks (w_wait_ticks)
    );

    // Slot sequencer.
    owtr_seq #(
        .READ_BYTES (READ_BYTES)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_action     (i_in.action),
        .i_rx_byte    (i_in.rx_byte),
        .i_wait_ticks (w_wait_ticks),
        .o_result     (w_result)
    );

    // Result register.
    owtr_outreg u_outreg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_accept),
        .i_result (w_result),
        .o_ready  (w_ready),
        .o_out    (o_out)
    );

`ifndef SYNTHESIS
    // A finished read always starts the next convert cycle with a reset slot.
    a_temp_starts_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.temp_valid |->
            o_out.tx_valid && o_out.slow_baud && o_out.tx_byte == SLOT_RESET)
        else $error("temperature result without a following reset slot");

    // Slow baud is used only for reset slots.
    a_slow_is_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.slow_baud |-> o_out.tx_valid && o_out.tx_byte == SLOT_RESET)
        else $error("slow baud on a non-reset slot");

    // The input stalls only behind a held result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> o_out.valid && !o_out.ready)
        else $error("input stalled without a pending result");
`endif

endmodule

[verif/onewire_uart_temp_reader_tb.sv]
`timescale 1ns / 1ps

module onewire_uart_temp_reader_tb;
    import owtr_pkg::*;

    localparam int READ_BYTES  = 9;
    localparam int READ_SLOTS  = READ_FIRST + 8 * READ_BYTES + 1;
    localparam int DUT_LATENCY = 1;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [2:0] ADDR_WAIT_TICKS = {REG_WAIT_TICKS, 2'b00};

    // One input transfer: a tick or a slot echo.
    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } t_wire_event;

    // Sequencer state as seen from outside.
    typedef struct {
        t_phase      phase;
        int          slot_idx;
        logic        slot_busy;
        logic [7:0]  ticks;
        logic [15:0] scratch;
    } t_seq_state;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    owtr_in_if  slot_in ();
    owtr_out_if slot_out ();

    onewire_uart_temp_reader #(
        .READ_BYTES(READ_BYTES)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (slot_in),
        .o_out  (slot_out),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    t_wire_event slot_events[$];
    t_result     expected_replies[$];
    t_seq_state  model_state;
    t_seq_state  gen_state;
    logic [7:0]  model_wait;
    logic [7:0]  gen_wait;
    logic        in_taken;
    logic        apb_done_q;
    logic [31:0] prdata_q;
    int          mismatches;
    int          transfers;
    int          results_seen;
    int          readings;
    int          temp_min;
    int          temp_max;
    int          gap_left;
    int          burst_left;
    int          stall_cyc;
    t_wire_event drive_ev;

    // Clock.
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Clear the read shift and begin the read cycle.
    function automatic void start_read(inout t_seq_state s);
        s.phase     = PH_READ;
        s.slot_idx  = 0;
        s.slot_busy = 1'b0;
        s.scratch   = '0;
    endfunction

    // Advance the sequencer by one input transfer and return its result.
    function automatic t_result sequence_step(inout t_seq_state s, input logic act,
                                              input logic [7:0] rx, input logic [7:0] wt);
        t_result    r;
        int         last;
        logic [7:0] cmd;
        r    = '0;
        last = (s.phase == PH_READ) ? READ_SLOTS : CONVERT_SLOTS;
        if (act && s.slot_busy && s.phase != PH_WAIT) begin
            // The echo closes the outstanding slot.
            s.slot_busy = 1'b0;
            if (s.phase == PH_READ && s.slot_idx >= READ_FIRST &&
                s.slot_idx < READ_FIRST + READ_BITS && rx == SLOT_ONE) begin
                s.scratch[s.slot_idx - READ_FIRST] = 1'b1;
            end
            s.slot_idx++;
            if (s.slot_idx >= last) begin
                if (s.phase == PH_READ) begin
                    r.temp_valid  = 1'b1;
                    r.temperature = s.scratch[11:0] & TEMP_MASK;
                    s.phase       = PH_CONVERT;
                    s.slot_idx    = 0;
                    s.scratch     = '0;
                end else begin
                    s.phase    = PH_WAIT;
                    s.ticks    = '0;
                    s.slot_idx = 0;
                    if (wt == 8'd0) start_read(s);
                end
            end
        end else if (!act && s.phase == PH_WAIT) begin
            // Conversion wait; the tick count saturates.
            if (s.ticks != 8'hFF) s.ticks++;
            if (s.ticks >= wt) start_read(s);
        end
        if (s.phase != PH_WAIT && !s.slot_busy) begin
            // Issue the next slot in the same result.
            cmd         = (s.phase == PH_READ) ? CMD_READ : CMD_CONVERT;
            r.tx_valid  = 1'b1;
            r.slow_baud = 1'b0;
            if (s.slot_idx == 0) begin
                r.tx_byte   = SLOT_RESET;
                r.slow_baud = 1'b1;
            end else if (s.slot_idx <= 8) begin
                r.tx_byte = CMD_SKIP[s.slot_idx - 1] ? SLOT_ONE : SLOT_ZERO;
            end else if (s.slot_idx <= 16) begin
                r.tx_byte = cmd[s.slot_idx - 9] ? SLOT_ONE : SLOT_ZERO;
            end else if (s.phase == PH_READ && s.slot_idx < READ_SLOTS - 1) begin
                r.tx_byte = SLOT_ONE;
            end else begin
                r.tx_byte   = SLOT_RESET;
                r.slow_baud = 1'b1;
            end
            s.slot_busy = 1'b1;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Queue one event and track where the sequence will stand after it.
    task automatic queue_event(input logic act, input logic [7:0] rx);
        t_wire_event ev;
        ev.action  = act;
        ev.rx_byte = rx;
        void'(sequence_step(gen_state, act, rx, gen_wait));
        slot_events.push_back(ev);
    endtask

    // Mostly well-formed traffic; the rest are ticks and echoes that are ignored.
    task automatic queue_random(input int budget);
        int         made;
        logic       noise;
        logic       act;
        logic [7:0] rx;
        made = 0;
        while (made < budget) begin
            noise = ($urandom_range(0, 6) == 0);
            act   = (gen_state.phase == PH_WAIT) ? noise : !noise;
            rx    = $urandom_range(0, 255);
            if (act && gen_state.phase == PH_READ && gen_state.slot_idx >= READ_FIRST &&
                gen_state.slot_idx < READ_FIRST + READ_BITS && $urandom_range(0, 1) == 1) begin
                rx = SLOT_ONE;
            end
            queue_event(act, rx);
            if (!noise) made++;
        end
    endtask

    // Hold the sender until every expected result has been taken.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (slot_events.size() != 0 || slot_in.valid || expected_replies.size() != 0);
        repeat (DUT_LATENCY + 2) @(negedge i_clk);
    endtask

    // APB access: setup cycle, then access until pready.
    task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(negedge i_clk);
        while (!apb_done_q);
        rdata = prdata_q;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_wait_ticks(input logic [7:0] value);
        logic [31:0] rd;
        apb_access(1'b1, ADDR_WAIT_TICKS, {24'h0, value}, rd);
        model_wait = value;
        gen_wait   = value;
        apb_access(1'b0, ADDR_WAIT_TICKS, 32'h0, rd);
        if (rd !== {24'h0, value}) begin
            $display("%0t: wait_ticks readback mismatch: expected %0d, actual %0d",
                     $time, value, rd);
            mismatches++;
        end
    endtask

    // Driver: bursts of transfers separated by random gaps.
    always @(negedge i_clk) begin
        if (in_taken || !slot_in.valid) begin
            if (gap_left != 0 || slot_events.size() == 0) begin
                slot_in.valid <= 1'b0;
                if (gap_left != 0) gap_left = gap_left - 1;
            end else begin
                drive_ev = slot_events.pop_front();
                slot_in.valid   <= 1'b1;
                slot_in.action  <= drive_ev.action;
                slot_in.rx_byte <= drive_ev.rx_byte;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                end else begin
                    burst_left = burst_left - 1;
                end
            end
        end
    end

    // Receiver: the stall pattern steps through four modes: always ready, alternating, random and periodic.
    always @(negedge i_clk) begin
        stall_cyc = stall_cyc + 1;
        case ((stall_cyc / 256) % 4)
            0: begin
                slot_out.ready <= 1'b1;
            end
            1: begin
                slot_out.ready <= (stall_cyc % 2) == 0;
            end
            2: begin
                slot_out.ready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                slot_out.ready <= (stall_cyc % 13) < 8;
            end
        endcase
    end

    // Monitor: check each output transfer, predict each input transfer.
    always @(posedge i_clk) begin
        t_result want;
        in_taken   <= i_rst_n && slot_in.valid && slot_in.ready;
        apb_done_q <= psel && penable && pready;
        prdata_q   <= prdata;
        if (i_rst_n) begin
            if (slot_out.valid && slot_out.ready) begin
                results_seen++;
                if (expected_replies.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual tx %h temp %0d",
                             $time, slot_out.tx_byte, slot_out.temperature);
                    mismatches++;
                end else begin
                    want = expected_replies.pop_front();
                    check_field("tx_valid", want.tx_valid, slot_out.tx_valid);
                    check_field("tx_byte", want.tx_byte, slot_out.tx_byte);
                    check_field("slow_baud", want.slow_baud, slot_out.slow_baud);
                    check_field("temp_valid", want.temp_valid, slot_out.temp_valid);
                    check_field("temperature", want.temperature, slot_out.temperature);
                    if (want.temp_valid) begin
                        readings++;
                        if (want.temperature < temp_min) temp_min = want.temperature;
                        if (want.temperature > temp_max) temp_max = want.temperature;
                    end
                end
            end
            if (slot_in.valid && slot_in.ready) begin
                transfers++;
                expected_replies.push_back(sequence_step(model_state, slot_in.action,
                                                         slot_in.rx_byte, model_wait));
            end
        end
    end

    // Watchdog.
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("%0t: timeout with %0d results still expected", $time, expected_replies.size());
        $display("onewire_uart_temp_reader verification failed");
        $finish;
    end

    // Stimulus sequence.
    initial begin
        int k;
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        slot_in.valid   = 1'b0;
        slot_in.action  = 1'b0;
        slot_in.rx_byte = '0;
        slot_out.ready  = 1'b0;
        in_taken        = 1'b0;
        apb_done_q      = 1'b0;
        prdata_q        = '0;
        mismatches      = 0;
        transfers       = 0;
        results_seen    = 0;
        readings        = 0;
        temp_min        = 2047;
        temp_max        = -2048;
        gap_left        = 0;
        burst_left      = 1;
        stall_cyc       = 0;
        model_wait      = WAIT_TICKS_RESET;
        gen_wait        = WAIT_TICKS_RESET;
        model_state     = '{PH_CONVERT, 0, 1'b0, 8'h00, 16'h0000};
        gen_state       = model_state;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: stray echo right after reset, a tick during a slot cycle,
        // a full convert cycle, a stray echo while waiting, then the wait ends.
        queue_event(1'b1, SLOT_ONE);
        queue_event(1'b0, 8'h00);
        for (k = 0; k < CONVERT_SLOTS; k++) begin
            case (k % 4)
                0: queue_event(1'b1, 8'h00);
                1: queue_event(1'b1, 8'hFF);
                2: queue_event(1'b1, 8'hA5);
                default: queue_event(1'b1, 8'h5A);
            endcase
        end
        queue_event(1'b1, SLOT_ONE);
        queue_event(1'b0, 8'hFF);
        queue_event(1'b0, 8'h00);

        // Random phases at several wait settings, extremes included.
        // The first budget finishes the read cycle, the second runs a convert
        // cycle through the longest wait, the third takes the zero-wait path.
        queue_random(90);
        wait_idle();
        write_wait_ticks(8'd255);
        queue_random(272);
        wait_idle();
        write_wait_ticks(8'd0);
        queue_random(107);
        wait_idle();

        $display("Run covered %0d input transfers and %0d results, %0d temperature readings",
                 transfers, results_seen, readings);
        $display("from %0d to %0d sixteenths, with wait_ticks at 2, 255 and 0.",
                 temp_min, temp_max);
        if (mismatches == 0 && expected_replies.size() == 0) begin
            $display("onewire_uart_temp_reader verification clean");
        end else begin
            $display("onewire_uart_temp_reader verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/owtr_pkg.sv
hw/rtl/owtr_if.sv
hw/rtl/owtr_apb.sv
hw/rtl/owtr_seq.sv
hw/rtl/owtr_outreg.sv
hw/rtl/onewire_uart_temp_reader.sv
verif/onewire_uart_temp_reader_tb.sv
